FILE: design/ss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ss_pkg
// Shared types and fixed widths for the substring search block.
// ----------------------------------------------------------------------------
package ss_pkg;

    localparam int CFG_DATA_W    = 64;  // widest config register
    localparam int CFG_IDX_W     = 2;
    localparam int LEN_W         = 5;   // pattern_length register width
    localparam int PATTERN_BYTES = 16;  // bytes held by the two pattern registers
    localparam int PAT_IDX_W     = 4;
    localparam int MATCH_IDX_W   = 16;

    typedef logic [7:0] byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    // one haystack byte moving from the input stage into the scanner
    typedef struct packed {
        logic  valid;
        byte_t text_byte;
        logic  end_of_text;
    } scan_in_t;

    typedef struct packed {
        logic                   found;
        logic [MATCH_IDX_W-1:0] match_start;
    } result_t;

endpackage

FILE: design/ss_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ss_cfg
// Pattern registers; presents the pattern right-aligned per compare lane.
// ----------------------------------------------------------------------------
module ss_cfg import ss_pkg::*; #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output byte_t                 pattern_lane [MAX_PATTERN],
    output logic [MAX_PATTERN-1:0] lane_en,
    output logic [LEN_W-1:0]      pattern_len
);

    logic [CFG_DATA_W-1:0] pat_low_reg,  pat_low_next;
    logic [CFG_DATA_W-1:0] pat_high_reg, pat_high_next;
    logic [LEN_W-1:0]      len_reg,      len_next;
    byte_t                 pat_bytes [PATTERN_BYTES];

    always_comb begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        len_next      = len_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PATTERN_LOW:    pat_low_next  = cfg_data;
                CFG_PATTERN_HIGH:   pat_high_next = cfg_data;
                CFG_PATTERN_LENGTH: len_next      = cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= '0;
        end else begin
            pat_low_reg  <= pat_low_next;
            pat_high_reg <= pat_high_next;
            len_reg      <= len_next;
        end
    end

    // lengths above the lane count act as the lane count
    assign pattern_len = (len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_reg;

    for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_bytes
        if (k < 8) begin : g_lo
            assign pat_bytes[k] = pat_low_reg[8*k +: 8];
        end else begin : g_hi
            assign pat_bytes[k] = pat_high_reg[8*(k-8) +: 8];
        end
    end

    // lane i holds the pattern byte that must equal the byte seen i bytes ago
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_lane
        logic [LEN_W-1:0] sel;
        assign sel             = pattern_len - LEN_W'(i + 1);
        assign pattern_lane[i] = pat_bytes[sel[PAT_IDX_W-1:0]];
        assign lane_en[i]      = LEN_W'(i) < pattern_len;
    end

endmodule

FILE: design/ss_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ss_scan
// Byte window, position count and first-match tracking; parallel compare.
// ----------------------------------------------------------------------------
module ss_scan import ss_pkg::*; #(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_TEXT    = 65536
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  scan_in_t               scan_in,
    input  byte_t                  pattern_lane [MAX_PATTERN],
    input  logic [MAX_PATTERN-1:0] lane_en,
    input  logic [LEN_W-1:0]       pattern_len,
    output result_t                result
);

    localparam int POS_W     = $clog2(MAX_TEXT + 1);
    localparam int WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

    byte_t                  window_reg  [WIN_DEPTH];
    byte_t                  window_next [WIN_DEPTH];
    byte_t                  history     [MAX_PATTERN];
    logic [POS_W-1:0]       pos_reg,        pos_next;
    logic                   match_seen_reg, match_seen_next;
    logic [MATCH_IDX_W-1:0] first_idx_reg,  first_idx_next;

    logic [MAX_PATTERN-1:0] lane_ok;
    logic                   in_range, reach, hit, seen_now, empty_pat;
    logic [POS_W:0]         pos_plus, start_full;
    logic [MATCH_IDX_W-1:0] idx_now;

    // history[0] is the incoming byte, history[i] the byte i steps back
    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cmp
        if (i == 0) begin : g_new
            assign history[i] = scan_in.text_byte;
        end else begin : g_old
            assign history[i] = window_reg[i-1];
        end
        assign lane_ok[i] = !lane_en[i] || (history[i] == pattern_lane[i]);
    end

    assign empty_pat  = (pattern_len == '0);
    assign in_range   = pos_reg < POS_W'(MAX_TEXT);
    assign pos_plus   = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign reach      = pos_plus >= (POS_W+1)'(pattern_len);
    assign start_full = pos_plus - (POS_W+1)'(pattern_len);
    assign hit        = in_range && !empty_pat && reach && !match_seen_reg && (&lane_ok);
    assign seen_now   = match_seen_reg || hit;
    assign idx_now    = hit ? MATCH_IDX_W'(start_full) : first_idx_reg;

    always_comb begin
        result.found       = empty_pat || seen_now;
        result.match_start = (!empty_pat && seen_now) ? idx_now : '0;
    end

    always_comb begin
        window_next[0] = scan_in.text_byte;
        for (int j = 1; j < WIN_DEPTH; j++) begin
            window_next[j] = window_reg[j-1];
        end
    end

    always_comb begin
        pos_next        = pos_reg;
        match_seen_next = match_seen_reg;
        first_idx_next  = first_idx_reg;
        if (scan_in.valid) begin
            if (scan_in.end_of_text) begin
                pos_next        = '0;
                match_seen_next = 1'b0;
                first_idx_next  = '0;
            end else if (in_range) begin
                pos_next        = pos_plus[POS_W-1:0];
                match_seen_next = seen_now;
                first_idx_next  = idx_now;
            end
        end
    end

    // window contents are only read once enough bytes have arrived
    always_ff @(posedge aclk) begin
        if (scan_in.valid && in_range) begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            match_seen_reg <= 1'b0;
            first_idx_reg  <= '0;
        end else begin
            pos_reg        <= pos_next;
            match_seen_reg <= match_seen_next;
            first_idx_reg  <= first_idx_next;
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_in.valid && scan_in.end_of_text |=> (pos_reg == '0) && !match_seen_reg)
        else $error("scan state not cleared after last byte");

    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_TEXT))
        else $error("position count beyond limit");

endmodule

FILE: design/substring_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_search
// First-occurrence search of a pattern of up to 16 bytes in a byte stream.
// ----------------------------------------------------------------------------
//
//  channel  ports                               direction  item
//  -------  ----------------------------------  ---------  ----------------------
//  input    s_valid/s_ready, s_text_byte,        in         one haystack byte
//           s_end_of_text
//  result   m_valid/m_ready, m_found,            out        one per marked last
//           m_match_start                                   byte
//  config   cfg_wr_en, cfg_index, cfg_data       in         register write
//
//  Throughput: one byte per cycle, except while a last byte waits (see Stalls).
//  A byte is registered on transfer, compared against the window while it sits
//  in the input register, and its result (if last) is registered for m_valid.
//  The window compare is fully parallel, one lane per pattern byte, so the
//  rate is set by the combinational path through the lane compare and AND.
//  Stalls: non-last bytes never wait on m_ready; a last byte waits in the input
//  register only while the result register is still held by the sink.
//  Reset (aresetn low, synchronous) clears both handshake stages, the scan
//  state and the pattern registers.
// ----------------------------------------------------------------------------
module substring_search import ss_pkg::*; #(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_TEXT    = 65536
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // haystack input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_text_byte,
    input  logic                   s_end_of_text,
    // search result
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_found,
    output logic [MATCH_IDX_W-1:0] m_match_start
);

    byte_t                  pattern_lane [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] lane_en;
    logic [LEN_W-1:0]       pattern_len;

    // input stage
    logic  in_valid_reg, in_valid_next;
    byte_t in_byte_reg;
    logic  in_eot_reg;
    logic  advance;

    // result stage
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t scan_result;
    scan_in_t scan_in;

    ss_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pattern_lane (pattern_lane),
        .lane_en      (lane_en),
        .pattern_len  (pattern_len)
    );

    // the input stage moves on unless it holds a last byte whose result
    // has nowhere to go
    assign advance = in_valid_reg && (!in_eot_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        scan_in.valid       = advance;
        scan_in.text_byte   = in_byte_reg;
        scan_in.end_of_text = in_eot_reg;
    end

    ss_scan #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .scan_in      (scan_in),
        .pattern_lane (pattern_lane),
        .lane_en      (lane_en),
        .pattern_len  (pattern_len),
        .result       (scan_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_eot_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_eot_reg  <= s_end_of_text;
        end
        if (advance && in_eot_reg) begin
            out_reg <= scan_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_found       = out_reg.found;
    assign m_match_start = out_reg.match_start;

    a_last_waits_on_full_output: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_eot_reg && out_valid_reg && !m_ready |-> !s_ready && !advance)
        else $error("last byte advanced into a held result");

    a_not_found_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.found |-> out_reg.match_start == '0)
        else $error("nonzero start index on not-found result");

    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_eot_reg |=> out_valid_reg)
        else $error("result lost after last byte");

endmodule

FILE: bench/search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_checker
// Mirrors the pattern registers and scan state from the observed transfers,
// predicts the search report of each haystack and compares it with the block.
// ----------------------------------------------------------------------------
module search_checker import ss_pkg::*; #(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_TEXT    = 65536
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [7:0]             s_text_byte,
    input  logic                   s_end_of_text,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic                   m_found,
    input  logic [MATCH_IDX_W-1:0] m_match_start,
    output int                     mismatches,
    output int                     pending
);

    logic [CFG_DATA_W-1:0]  pat_lo;
    logic [CFG_DATA_W-1:0]  pat_hi;
    logic [LEN_W-1:0]       pat_len;

    byte_t                  window [MAX_PATTERN-1];   // newest byte at 0
    int unsigned            pos;
    logic                   hit_seen;
    logic [MATCH_IDX_W-1:0] hit_start;

    result_t                search_reports [$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic byte_t pattern_byte(input int k);
        logic [2*CFG_DATA_W-1:0] p;
        p = {pat_hi, pat_lo};
        return p[8*k +: 8];
    endfunction

    task automatic clear_scan();
        for (int i = 0; i < MAX_PATTERN-1; i++) window[i] = '0;
        pos       = 0;
        hit_seen  = 1'b0;
        hit_start = '0;
    endtask

    task automatic scan_byte(input byte_t c, input logic last);
        int          n;
        bit          ok;
        int unsigned start;
        result_t     r;
        n = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
        // bytes past the text limit are not compared and do not move the window
        if (pos < MAX_TEXT) begin
            if (n > 0 && pos + 1 >= n && !hit_seen) begin
                ok = (pattern_byte(n-1) == c);
                for (int i = 1; i < n; i++)
                    if (pattern_byte(n-1-i) != window[i-1]) ok = 1'b0;
                if (ok) begin
                    start     = pos + 1 - n;
                    hit_seen  = 1'b1;
                    hit_start = start[MATCH_IDX_W-1:0];
                end
            end
            pos++;
            for (int i = MAX_PATTERN-2; i > 0; i--) window[i] = window[i-1];
            window[0] = c;
        end
        if (last) begin
            r.found       = (n == 0) || hit_seen;
            r.match_start = (n != 0 && hit_seen) ? hit_start : '0;
            search_reports.insert(search_reports.size(), r);
            clear_scan();
        end
    endtask

    task automatic check_report(input logic f, input logic [MATCH_IDX_W-1:0] st);
        result_t want;
        if (search_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected report: found=%0d match_start=%0d",
                         $realtime, f, st);
        end else begin
            want = search_reports.pop_front();
            if (want.found !== f || want.match_start !== st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] expected found=%0d start=%0d, got found=%0d start=%0d",
                             $realtime, want.found, want.match_start, f, st);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo  = '0;
            pat_hi  = '0;
            pat_len = '0;
            clear_scan();
            search_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_PATTERN_LOW:    pat_lo  = cfg_data;
                    CFG_PATTERN_HIGH:   pat_hi  = cfg_data;
                    CFG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) scan_byte(s_text_byte, s_end_of_text);
            if (m_valid && m_ready) check_report(m_found, m_match_start);
        end
        pending = search_reports.size();
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Substring search bench: streams directed and random haystacks through the
// block under several pattern settings while both channels stall at random;
// the checker predicts and compares every search report.
// ----------------------------------------------------------------------------
module tb import ss_pkg::*;;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_TEXT    = 65536;
    localparam int STALL_LIMIT = 2000;  // cycles without any transfer
    localparam int RANDOM_BYTES = 820;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [7:0]             s_text_byte;
    logic                   s_end_of_text;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_found;
    logic [MATCH_IDX_W-1:0] m_match_start;

    int mismatches;
    int pending;
    int stall_cycles = 0;

    // no idling on either side while set
    bit quiet = 1'b0;

    // current pattern, kept here so haystacks can plant it
    logic [CFG_DATA_W-1:0] cur_lo;
    logic [CFG_DATA_W-1:0] cur_hi;
    logic [LEN_W-1:0]      cur_len;

    byte_t haystack [$];

    substring_search #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_match_start (m_match_start)
    );

    search_checker #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_match_start (m_match_start),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result side: ready is redrawn every falling edge, low about 36% of
    // the time, so stalls land on any cycle of a report's life.
    always @(negedge aclk) begin
        m_ready <= aresetn && (quiet || $urandom_range(99) >= 36);
    end

    // Watchdog: any cycle with neither a byte nor a report transfer counts.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // One byte transfer. Called at a falling edge, returns at a falling edge.
    // The random gap comes before valid rises; once up, valid and the payload
    // hold until the byte is taken.
    task automatic send_byte(input byte_t b, input logic last);
        while (!quiet && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_text_byte   <= b;
        s_end_of_text <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_haystack();
        for (int i = 0; i < haystack.size(); i++)
            send_byte(haystack[i], i == haystack.size() - 1);
    endtask

    // Drop valid and hold off until every report is back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
    endtask

    // All three registers each time; only call while idle.
    task automatic set_pattern(input logic [CFG_DATA_W-1:0] lo,
                               input logic [CFG_DATA_W-1:0] hi,
                               input logic [LEN_W-1:0] len);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LENGTH, {{(CFG_DATA_W-LEN_W){1'b0}}, len});
        cfg_wr_en <= 1'b0;
        cur_lo  = lo;
        cur_hi  = hi;
        cur_len = len;
    endtask

    // Random haystack. Most are built from pattern bytes with the pattern
    // planted somewhere (sometimes with one bit broken); the rest is noise
    // over the full byte range, or over 41h/42h only for a narrow alphabet.
    task automatic build_haystack(input bit narrow);
        int                      n;
        int                      kind;
        int                      eff;
        int                      at;
        int                      k;
        logic [2*CFG_DATA_W-1:0] p;
        byte_t                   b;
        p    = {cur_hi, cur_lo};
        eff  = (cur_len > MAX_PATTERN) ? MAX_PATTERN : int'(cur_len);
        n    = $urandom_range(1, 28);
        kind = $urandom_range(0, 9);
        haystack.delete();
        for (int i = 0; i < n; i++) begin
            if (narrow)
                b = 8'h41 + 8'($urandom_range(0, 1));
            else if (kind < 7 && eff > 0 && $urandom_range(0, 3) != 0)
                b = p[8*$urandom_range(0, eff-1) +: 8];
            else
                b = 8'($urandom_range(0, 255));
            haystack.insert(haystack.size(), b);
        end
        if (kind < 7 && eff > 0 && n >= eff) begin
            at = $urandom_range(0, n - eff);
            for (int i = 0; i < eff; i++) haystack[at+i] = p[8*i +: 8];
            // broken occurrence: flip one bit of one planted byte
            if (kind == 6) begin
                k = $urandom_range(0, eff-1);
                haystack[at+k] = haystack[at+k] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
    endtask

    initial begin
        int                    sent;
        int                    setting;
        int                    sel;
        bit                    narrow;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [LEN_W-1:0]      len;

        // every input known from time zero; reset asserted first
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_PATTERN_LOW;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_text_byte   = '0;
        s_end_of_text = 1'b0;
        m_ready       = 1'b0;
        cur_lo        = '0;
        cur_hi        = '0;
        cur_len       = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed ----
        // empty pattern straight out of reset: found at index 0
        haystack = '{8'h00};
        send_haystack();

        // two-byte pattern FF 00 over extreme byte values: first hit at 1
        wait_idle();
        set_pattern(64'h0000_0000_0000_00FF, '0, 5'd2);
        haystack = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
        send_haystack();
        // haystack shorter than the pattern
        haystack = '{8'hFF};
        send_haystack();

        // oversized length register clamps to the full 16 bytes
        wait_idle();
        set_pattern(64'h0706_0504_0302_0100, '1, 5'd31);
        haystack.delete();
        for (int i = 0; i < 16; i++)
            haystack.insert(haystack.size(), i < 8 ? byte_t'(i) : 8'hFF);
        send_haystack();

        // ---- random settings, a handful of haystacks each ----
        sent    = 0;
        setting = 0;
        while (sent < RANDOM_BYTES) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       len = 5'd0;
                1:       len = 5'd16;
                2:       len = 5'($urandom_range(17, 31));
                3:       len = 5'd1;
                default: len = 5'($urandom_range(2, 15));
            endcase
            // narrow alphabet gives heavy overlap of partial matches
            narrow = ($urandom_range(0, 2) == 0);
            if (narrow) begin
                for (int i = 0; i < 8; i++) begin
                    lo[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 1));
                    hi[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 1));
                end
            end else begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            // config changes double as a full drain of the report queue
            wait_idle();
            set_pattern(lo, hi, len);
            // one setting runs with no idling anywhere
            quiet = (setting == 3);
            repeat ($urandom_range(4, 10)) begin
                build_haystack(narrow);
                sent += haystack.size();
                send_haystack();
            end
            setting++;
        end
        quiet = 1'b0;

        // drain and verdict
        wait_idle();
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
